>>> sv/jdtm_pkg.sv
// jdtm_pkg: types, codes and constants shared by the jtag debug transaction master
// and its checker; no dependencies

package jdtm_pkg;

    localparam int DATA_BITS = 32;
    localparam int IR_BITS   = 4;
    localparam int CMD_BITS  = 4;
    localparam int CNT_W     = 6;

    localparam logic [15:0] RETRY_RESET = 16'd50;

    localparam logic [7:0] IR_DATA   = 8'h0B;
    localparam logic [7:0] IR_ADDR   = 8'h0A;
    localparam logic [7:0] IR_CMD    = 8'h09;
    localparam logic [7:0] IR_STATUS = 8'h08;

    localparam logic [2:0] CMD_READ_FLAG = 3'h4;
    localparam logic [2:0] CMD_WRITE_FLAG = 3'h0;
    localparam logic [2:0] STATUS_READY = 3'h4;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [1:0] OC_NONE    = 2'd0;
    localparam logic [1:0] OC_SUCCESS = 2'd1;
    localparam logic [1:0] OC_FAIL    = 2'd2;
    localparam logic [1:0] OC_TIMEOUT = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_OK        = 4'd1,
        PH_FAIL      = 4'd2,
        PH_TIMEOUT   = 4'd3,
        PH_RESET     = 4'd4,
        PH_RTI_START = 4'd5,
        PH_RTI_POLL  = 4'd6,
        PH_POST      = 4'd7,
        PH_OPS       = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        OP_DATA   = 3'd0,
        OP_ADDR   = 3'd1,
        OP_CMD    = 3'd2,
        OP_STATUS = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        SUB_SEL1 = 3'd0,
        SUB_IR   = 3'd1,
        SUB_SEL2 = 3'd2,
        SUB_DR   = 3'd3,
        SUB_UPD  = 3'd4
    } t_sub;

    typedef struct packed {
        logic        action;
        logic [1:0]  space;
        logic        is_write;
        logic [31:0] address;
        logic [31:0] write_data;
        logic        tdo;
    } t_in_req;

    typedef struct packed {
        logic        tms;
        logic        tdi;
        logic        tck_pulse;
        logic        busy_res;
        logic [1:0]  outcome;
        logic [31:0] read_data;
    } t_out_req;

    function automatic logic [7:0] op_ir(input t_op op);
        logic [7:0] ir;
        case (op)
            OP_ADDR:   ir = IR_ADDR;
            OP_CMD:    ir = IR_CMD;
            OP_STATUS: ir = IR_STATUS;
            default:   ir = IR_DATA;
        endcase
        return ir;
    endfunction

    function automatic logic [CNT_W:0] op_len(input t_op op);
        logic [CNT_W:0] len;
        len = (op == OP_CMD) ? (CNT_W+1)'(CMD_BITS) : (CNT_W+1)'(DATA_BITS);
        return len;
    endfunction

    function automatic logic phase_busy(input t_phase ph);
        logic b;
        b = (ph != PH_IDLE) && (ph != PH_OK) && (ph != PH_FAIL) && (ph != PH_TIMEOUT);
        return b;
    endfunction

endpackage

>>> sv/jtag_debug_transaction_master_unit.sv
// jtag_debug_transaction_master_unit: top level of the jtag debug transaction master
// depends on jdtm_pkg
//
// usage: a start request (action 0) latches space, direction, address and write data
// when no transaction is running; each tick request (action 1) carries the sampled tdo
// and yields the tms/tdi levels for one tck period. every request gives exactly one
// result with busy and outcome; the final pulse shows busy 0 and the outcome, and idle
// ticks repeat that outcome until the next start
// the retry limit register is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while idle, the block does not enforce this
// path: a request is captured in the input register, then the sequencer step runs and
// its result is written into the result register once that register is free or taken
// throughput: one request per cycle while the receiver takes results; the single
// sequencer step per request sets that figure
// reset: sequencer returns to idle, retry limit goes to 50, both register stages empty
// receiver stall: the result register holds, the input register fills, then o_in_ready
// drops until the result is taken

module jtag_debug_transaction_master_unit
    import jdtm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic           r_in_valid;
    t_in_req        r_in;
    logic           r_out_valid;
    t_out_req       r_out;
    logic [15:0]    r_retry;

    t_phase         r_phase, n_phase;
    t_op            r_op, n_op;
    t_sub           r_sub, n_sub;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]    r_shift, n_shift;
    logic [2:0]     r_status, n_status;
    logic [15:0]    r_poll, n_poll;
    logic [31:0]    r_addr, n_addr;
    logic [31:0]    r_data, n_data;
    logic [2:0]     r_cmd, n_cmd;

    logic           advance;
    logic           busy;
    logic           tick;
    logic [CNT_W:0] cnt_inc;
    logic [7:0]     ir_val;
    logic [CNT_W:0] dr_len;
    logic [31:0]    op_word;
    logic           tms, tdi;
    t_out_req       n_out;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign busy       = phase_busy(r_phase);
    assign tick       = (r_in.action == ACT_TICK) && busy;
    assign cnt_inc    = {1'b0, r_cnt} + (CNT_W+1)'(1);
    assign ir_val     = op_ir(r_op);
    assign dr_len     = op_len(r_op);

    always_comb begin
        case (r_op)
            OP_DATA: op_word = r_data;
            OP_ADDR: op_word = r_addr;
            OP_CMD:  op_word = {29'd0, r_cmd};
            default: op_word = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_op     = r_op;
        n_sub    = r_sub;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_status = r_status;
        n_poll   = r_poll;
        n_addr   = r_addr;
        n_data   = r_data;
        n_cmd    = r_cmd;
        if (r_in.action == ACT_START) begin
            if (!busy) begin
                n_addr   = r_in.address;
                n_data   = r_in.write_data;
                n_cmd    = (r_in.is_write ? CMD_WRITE_FLAG : CMD_READ_FLAG) |
                           {1'b0, r_in.space};
                n_phase  = PH_RESET;
                n_cnt    = '0;
                n_shift  = '0;
                n_status = '0;
                n_poll   = '0;
            end
        end else if (tick) begin
            unique case (r_phase)
                PH_RESET: begin
                    n_cnt = cnt_inc[CNT_W-1:0];
                    if (cnt_inc >= (CNT_W+1)'(6)) begin
                        n_cnt   = '0;
                        n_phase = PH_RTI_START;
                    end
                end
                PH_RTI_START: begin
                    n_cnt   = '0;
                    n_phase = PH_OPS;
                    n_op    = r_cmd[2] ? OP_ADDR : OP_DATA;
                    n_sub   = SUB_SEL1;
                end
                PH_RTI_POLL: begin
                    n_cnt  = '0;
                    n_poll = '0;
                    if (r_retry == 16'd0) begin
                        n_phase = PH_TIMEOUT;
                    end else begin
                        n_phase = PH_OPS;
                        n_op    = OP_STATUS;
                        n_sub   = SUB_SEL1;
                    end
                end
                PH_POST: begin
                    n_cnt = cnt_inc[CNT_W-1:0];
                    if (cnt_inc >= (CNT_W+1)'(2)) begin
                        n_cnt = '0;
                        if (r_status == STATUS_READY) begin
                            if (r_cmd[2]) begin
                                n_phase = PH_OPS;
                                n_op    = OP_READ;
                                n_sub   = SUB_SEL1;
                            end else begin
                                n_phase = PH_OK;
                            end
                        end else if (r_poll >= r_retry) begin
                            n_phase = PH_TIMEOUT;
                        end else begin
                            n_phase = PH_OPS;
                            n_op    = OP_STATUS;
                            n_sub   = SUB_SEL1;
                        end
                    end
                end
                PH_OPS: begin
                    unique case (r_sub)
                        SUB_SEL1, SUB_SEL2: begin
                            n_cnt = cnt_inc[CNT_W-1:0];
                            if (cnt_inc >= (CNT_W+1)'(4)) begin
                                n_cnt = '0;
                                if (r_sub == SUB_SEL1) begin
                                    n_sub = SUB_IR;
                                end else begin
                                    n_sub    = SUB_DR;
                                    n_shift  = op_word;
                                    n_status = '0;
                                end
                            end
                        end
                        SUB_IR: begin
                            if (cnt_inc >= (CNT_W+1)'(IR_BITS)) begin
                                n_cnt = '0;
                                n_sub = SUB_SEL2;
                            end else begin
                                n_cnt = cnt_inc[CNT_W-1:0];
                            end
                        end
                        SUB_DR: begin
                            if (r_op == OP_STATUS) begin
                                if (r_cnt < CNT_W'(3)) begin
                                    n_status = r_status |
                                               (3'(r_in.tdo) << r_cnt[1:0]);
                                end
                                if (r_in.tdo && r_cnt == CNT_W'(1)) begin
                                    n_cnt   = '0;
                                    n_phase = PH_FAIL;
                                end else if (r_in.tdo || r_cnt >= CNT_W'(2)) begin
                                    n_cnt   = '0;
                                    n_poll  = r_poll + 16'd1;
                                    n_phase = PH_POST;
                                end else begin
                                    n_cnt = cnt_inc[CNT_W-1:0];
                                end
                            end else begin
                                if (r_cnt < CNT_W'(32)) begin
                                    n_shift[r_cnt[4:0]] = r_in.tdo;
                                end
                                if (cnt_inc >= dr_len) begin
                                    n_cnt = '0;
                                    n_sub = SUB_UPD;
                                end else begin
                                    n_cnt = cnt_inc[CNT_W-1:0];
                                end
                            end
                        end
                        default: begin
                            n_cnt = '0;
                            unique case (r_op)
                                OP_DATA: begin
                                    n_op  = OP_ADDR;
                                    n_sub = SUB_SEL1;
                                end
                                OP_ADDR: begin
                                    n_op  = OP_CMD;
                                    n_sub = SUB_SEL1;
                                end
                                OP_CMD:  n_phase = PH_RTI_POLL;
                                default: n_phase = PH_OK;
                            endcase
                        end
                    endcase
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // pin levels for this request
    always_comb begin
        tms = 1'b0;
        tdi = 1'b0;
        if (tick) begin
            unique case (r_phase)
                PH_RESET, PH_POST: tms = 1'b1;
                PH_OPS: begin
                    unique case (r_sub)
                        SUB_SEL1, SUB_SEL2: tms = (r_cnt < CNT_W'(2));
                        SUB_IR: begin
                            tdi = (r_cnt < CNT_W'(8)) ? ir_val[r_cnt[2:0]] : 1'b0;
                            tms = (cnt_inc >= (CNT_W+1)'(IR_BITS));
                        end
                        SUB_DR: begin
                            if (r_op != OP_STATUS) begin
                                tdi = (r_cnt < CNT_W'(32)) ? r_shift[r_cnt[4:0]] : 1'b0;
                                tms = (cnt_inc >= dr_len);
                            end
                        end
                        default: tms = 1'b1;
                    endcase
                end
                default: tms = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_out.tms       = tms;
        n_out.tdi       = tdi;
        n_out.tck_pulse = tick;
        n_out.busy_res  = phase_busy(n_phase);
        case (n_phase)
            PH_OK:      n_out.outcome = OC_SUCCESS;
            PH_FAIL:    n_out.outcome = OC_FAIL;
            PH_TIMEOUT: n_out.outcome = OC_TIMEOUT;
            default:    n_out.outcome = OC_NONE;
        endcase
        n_out.read_data = (n_phase == PH_OK && n_cmd[2]) ? n_shift : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_retry     <= RETRY_RESET;
            r_phase     <= PH_IDLE;
            r_op        <= OP_DATA;
            r_sub       <= SUB_SEL1;
            r_cnt       <= '0;
            r_shift     <= '0;
            r_status    <= '0;
            r_poll      <= '0;
            r_addr      <= '0;
            r_data      <= '0;
            r_cmd       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_retry <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_op        <= n_op;
                r_sub       <= n_sub;
                r_cnt       <= n_cnt;
                r_shift     <= n_shift;
                r_status    <= n_status;
                r_poll      <= n_poll;
                r_addr      <= n_addr;
                r_data      <= n_data;
                r_cmd       <= n_cmd;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> sv/jdtm_checker.sv
// jdtm_checker: port-level assertions for jtag_debug_transaction_master_unit
// depends on jdtm_pkg; attached to the top level by the bind below

module jdtm_checker
    import jdtm_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_req o_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("result changed while stalled");

    // no pin activity without a tck pulse
    a_quiet_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.tck_pulse |-> !o_out.tms && !o_out.tdi)
        else $error("tms or tdi set without a pulse");

    // a running transaction has no outcome
    a_busy_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.busy_res |-> o_out.outcome == OC_NONE)
        else $error("outcome reported while busy");

    // read data only accompanies success
    a_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.read_data != 32'd0 |-> o_out.outcome == OC_SUCCESS)
        else $error("read data without success");

endmodule

bind jtag_debug_transaction_master_unit jdtm_checker u_jdtm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

>>> tb/sv/jdtm_access_checker.sv
`timescale 1ns / 1ps
// jdtm_access_checker: predicts the tms/tdi/outcome stream of the jtag debug
// transaction master from the accepted requests and compares it with the results
// depends on jdtm_pkg

module jdtm_access_checker
    import jdtm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_in_req  i_in,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_out_req i_out,
    input  logic     i_cfg_we,
    input  logic     [15:0] i_cfg_wdata,
    output int       o_fail_count,
    output int       o_pending
);

    t_phase      seq_phase;
    t_op         seq_op;
    t_sub        seq_sub;
    logic [CNT_W-1:0] bit_pos;
    logic [31:0] shift_reg;
    logic [2:0]  status_seen;
    logic [15:0] polls_done;
    logic [31:0] access_addr;
    logic [31:0] access_data;
    logic [2:0]  access_cmd;
    logic [15:0] retry_limit_copy;
    t_out_req    tap_results_due[$];
    int          fail_total = 0;

    function automatic logic [7:0] instr_for(input t_op op);
        case (op)
            OP_ADDR:   return IR_ADDR;
            OP_CMD:    return IR_CMD;
            OP_STATUS: return IR_STATUS;
            default:   return IR_DATA;
        endcase
    endfunction

    function automatic logic reading_access();
        return (access_cmd & CMD_READ_FLAG) != 3'b000;
    endfunction

    task automatic enter_op(input t_op op);
        seq_phase = PH_OPS;
        seq_op    = op;
        seq_sub   = SUB_SEL1;
    endtask

    // one request through the tap sequencer: state update plus the result it gives
    task automatic tap_sequencer_step(input t_in_req r, output t_out_req res);
        logic       pulse;
        logic       tms_v;
        logic       tdi_v;
        logic [7:0] ir;
        int         pos;
        pulse = 1'b0;
        tms_v = 1'b0;
        tdi_v = 1'b0;
        pos   = int'(bit_pos);
        if (r.action == ACT_START) begin
            if (seq_phase < PH_RESET) begin
                access_addr = r.address;
                access_data = r.write_data;
                access_cmd  = (r.is_write ? CMD_WRITE_FLAG : CMD_READ_FLAG) | {1'b0, r.space};
                seq_phase   = PH_RESET;
                pos         = 0;
                shift_reg   = '0;
                status_seen = '0;
                polls_done  = '0;
            end
        end else if (seq_phase >= PH_RESET) begin
            pulse = 1'b1;
            case (seq_phase)
                PH_RESET: begin
                    tms_v = 1'b1;
                    pos++;
                    if (pos >= 6) begin
                        pos = 0;
                        seq_phase = PH_RTI_START;
                    end
                end
                PH_RTI_START: begin
                    pos = 0;
                    enter_op(reading_access() ? OP_ADDR : OP_DATA);
                end
                PH_RTI_POLL: begin
                    pos = 0;
                    polls_done = '0;
                    if (retry_limit_copy == 16'd0) seq_phase = PH_TIMEOUT;
                    else enter_op(OP_STATUS);
                end
                PH_POST: begin
                    tms_v = 1'b1;
                    pos++;
                    if (pos >= 2) begin
                        pos = 0;
                        if (status_seen == STATUS_READY) begin
                            if (reading_access()) enter_op(OP_READ);
                            else seq_phase = PH_OK;
                        end else if (polls_done >= retry_limit_copy) begin
                            seq_phase = PH_TIMEOUT;
                        end else begin
                            enter_op(OP_STATUS);
                        end
                    end
                end
                default: begin
                    case (seq_sub)
                        SUB_SEL1, SUB_SEL2: begin
                            tms_v = (pos < 2);
                            pos++;
                            if (pos >= 4) begin
                                pos = 0;
                                if (seq_sub == SUB_SEL1) begin
                                    seq_sub = SUB_IR;
                                end else begin
                                    seq_sub = SUB_DR;
                                    status_seen = '0;
                                    case (seq_op)
                                        OP_DATA: shift_reg = access_data;
                                        OP_ADDR: shift_reg = access_addr;
                                        OP_CMD:  shift_reg = {29'd0, access_cmd};
                                        default: shift_reg = '0;
                                    endcase
                                end
                            end
                        end
                        SUB_IR: begin
                            ir = instr_for(seq_op);
                            if (pos < 8) tdi_v = ir[pos];
                            if (pos + 1 >= IR_BITS) begin
                                tms_v = 1'b1;
                                pos = 0;
                                seq_sub = SUB_SEL2;
                            end else begin
                                pos++;
                            end
                        end
                        SUB_DR: begin
                            if (seq_op == OP_STATUS) begin
                                if (pos < 3) status_seen[pos] = status_seen[pos] | r.tdo;
                                if (r.tdo && pos == 1) begin
                                    pos = 0;
                                    seq_phase = PH_FAIL;
                                end else if (r.tdo || pos >= 2) begin
                                    pos = 0;
                                    polls_done = polls_done + 16'd1;
                                    seq_phase = PH_POST;
                                end else begin
                                    pos++;
                                end
                            end else begin
                                if (pos < 32) begin
                                    tdi_v = shift_reg[pos];
                                    shift_reg[pos] = r.tdo;
                                end
                                if (pos + 1 >= ((seq_op == OP_CMD) ? CMD_BITS : DATA_BITS)) begin
                                    tms_v = 1'b1;
                                    pos = 0;
                                    seq_sub = SUB_UPD;
                                end else begin
                                    pos++;
                                end
                            end
                        end
                        default: begin
                            tms_v = 1'b1;
                            pos = 0;
                            case (seq_op)
                                OP_DATA: enter_op(OP_ADDR);
                                OP_ADDR: enter_op(OP_CMD);
                                OP_CMD:  seq_phase = PH_RTI_POLL;
                                default: seq_phase = PH_OK;
                            endcase
                        end
                    endcase
                end
            endcase
        end
        bit_pos       = pos[CNT_W-1:0];
        res.tms       = tms_v;
        res.tdi       = tdi_v;
        res.tck_pulse = pulse;
        res.busy_res  = (seq_phase >= PH_RESET);
        res.outcome   = (seq_phase >= PH_RESET) ? OC_NONE : 2'(seq_phase);
        res.read_data = (seq_phase == PH_OK && reading_access()) ? shift_reg : 32'd0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_req res;
        t_out_req exp_r;
        if (!i_rst_n) begin
            seq_phase        = PH_IDLE;
            seq_op           = OP_DATA;
            seq_sub          = SUB_SEL1;
            bit_pos          = '0;
            shift_reg        = '0;
            status_seen      = '0;
            polls_done       = '0;
            access_addr      = '0;
            access_data      = '0;
            access_cmd       = '0;
            retry_limit_copy = RETRY_RESET;
            tap_results_due.delete();
        end else begin
            if (i_cfg_we) retry_limit_copy = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                tap_sequencer_step(i_in, res);
                tap_results_due.push_back(res);
            end
            if (i_out_valid && i_out_ready) begin
                if (tap_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %0h", $time, i_out);
                    fail_total++;
                end else begin
                    exp_r = tap_results_due.pop_front();
                    check_field("tms", exp_r.tms, i_out.tms);
                    check_field("tdi", exp_r.tdi, i_out.tdi);
                    check_field("tck_pulse", exp_r.tck_pulse, i_out.tck_pulse);
                    check_field("busy_res", exp_r.busy_res, i_out.busy_res);
                    check_field("outcome", exp_r.outcome, i_out.outcome);
                    check_field("read_data", exp_r.read_data, i_out.read_data);
                end
            end
        end
        o_pending    <= tap_results_due.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> tb/sv/tb_jtag_debug_transaction_master_unit.sv
`timescale 1ns / 1ps
// tb_jtag_debug_transaction_master_unit: drives debug accesses and tdo streams into the
// jtag debug transaction master, with random gaps and stalls, and gives the verdict
// depends on jdtm_pkg, jdtm_access_checker and jtag_debug_transaction_master_unit

module tb_jtag_debug_transaction_master_unit;
    import jdtm_pkg::*;

    localparam int TDO_HALF       = 0;
    localparam int TDO_SPARSE     = 1;
    localparam int TDO_ONES       = 2;
    localparam int TDO_ZEROS      = 3;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int ITEM_TARGET    = 750;
    localparam int MAX_IDLE       = 13;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_req     in_req = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_req    out_res;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int done_count = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    int taken = 0;
    int sent = 0;
    int cur_limit = RETRY_RESET;
    logic gaps_on = 1'b1;
    logic stalls_on = 1'b1;

    always #2 clk = ~clk;

    jtag_debug_transaction_master_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    jdtm_access_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_res),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side stalls
    always @(posedge clk) begin : receiver
        int n;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            n = stall_left;
            if (out_valid && out_ready) begin
                if (taken % 64 == 0) stalls_on = ($urandom_range(0, 3) != 0);
                taken++;
                n = stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
            end else if (n > 0) begin
                n--;
            end
            stall_left <= n;
            out_ready  <= (n == 0);
        end
    end

    // a finished access shows its last pulse with busy low
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready && out_res.tck_pulse && !out_res.busy_res)
            done_count <= done_count + 1;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_req random_req(input logic act);
        t_in_req r;
        r.action     = act;
        r.space      = 2'($urandom_range(0, 3));
        r.is_write   = 1'($urandom_range(0, 1));
        r.address    = $urandom;
        r.write_data = $urandom;
        r.tdo        = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic logic tdo_for(input int mode);
        case (mode)
            TDO_HALF:   return 1'($urandom_range(0, 1));
            TDO_SPARSE: return ($urandom_range(0, 3) == 0);
            TDO_ONES:   return 1'b1;
            default:    return 1'b0;
        endcase
    endfunction

    task automatic send_req(input t_in_req r);
        int gap;
        if (sent % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        sent++;
        gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_limit(input int value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 16'(value);
        cur_limit = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one debug access: start request, then ticks until the final pulse comes back
    task automatic run_access(input logic [1:0] space, input logic wr,
                              input logic [31:0] addr, input logic [31:0] data,
                              input int mode, output int ticks);
        t_in_req r;
        int base;
        int cap;
        repeat ($urandom_range(0, 2)) send_req(random_req(ACT_TICK));
        r            = random_req(ACT_START);
        r.space      = space;
        r.is_write   = wr;
        r.address    = addr;
        r.write_data = data;
        base = done_count;
        send_req(r);
        ticks = 0;
        cap = 400 + 20 * cur_limit;
        while (done_count == base && ticks < cap) begin
            // start while busy, kept early so it cannot land after completion
            if (ticks < 50 && (ticks == 3 || $urandom_range(0, 39) == 0))
                send_req(random_req(ACT_START));
            r = random_req(ACT_TICK);
            r.tdo = tdo_for(mode);
            send_req(r);
            ticks++;
        end
    endtask

    function automatic int pick_limit();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return 2;
            2:       return 3;
            3:       return RETRY_RESET;
            4:       return 65535;
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    function automatic int pick_mode(input int lim);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return TDO_HALF;
        if (sel < 8 || lim > 8) return TDO_SPARSE;
        return (sel == 8) ? TDO_ONES : TDO_ZEROS;
    endfunction

    initial begin : stimulus
        int n;
        int txn;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks before any access
        send_req(random_req(ACT_TICK));
        send_req(random_req(ACT_TICK));
        run_access(2'd0, 1'b0, 32'h0000_0000, 32'h0000_0000, TDO_HALF, n);
        run_access(2'd3, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TDO_HALF, n);

        // zero retry limit ends right after the command
        write_limit(0);
        run_access(2'd1, 1'b1, 32'h8000_0001, 32'h5A5A_A5A5, TDO_HALF, n);
        run_access(2'd2, 1'b0, 32'h7FFF_FFFE, 32'h0000_0000, TDO_HALF, n);

        // stalled status and all-zero status both run into the limit
        write_limit(1);
        run_access(2'd0, 1'b1, $urandom, $urandom, TDO_ONES, n);
        run_access(2'd2, 1'b0, $urandom, $urandom, TDO_ZEROS, n);

        write_limit(65535);
        run_access(2'd1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, TDO_SPARSE, n);

        // at least one random access, then more until the request budget is used
        txn = 0;
        do begin
            if (txn % 2 == 0) write_limit(pick_limit());
            run_access(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
                       $urandom, pick_mode(cur_limit), n);
            txn++;
        end while (sent < ITEM_TARGET);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
